### rtl/core/tlvp_pkg.sv
// ----------------------------------------------------------------------------
// tlvp_pkg
// Shared types and constants of the telemetry frame TLV parser.
// ----------------------------------------------------------------------------
package tlvp_pkg;

  // Header layout (byte positions within the 31-byte header)
  localparam int unsigned HdrLen = 31;
  localparam logic [4:0] PosIdHiStart = 5'd4;
  localparam logic [4:0] PosIdLoStart = 5'd12;
  localparam logic [4:0] PosHealth    = 5'd20;
  localparam logic [4:0] PosCountHi   = 5'd29;
  localparam logic [4:0] PosLast      = 5'(HdrLen - 1);

  localparam logic [7:0] Magic [4] = '{8'h52, 8'h48, 8'h4D, 8'h53};

  // Value type codes
  localparam logic [7:0] TypeDouble = 8'd0;
  localparam logic [7:0] TypeInt    = 8'd1;
  localparam logic [7:0] TypeString = 8'd2;

  localparam logic [7:0] DoubleLen = 8'd8;
  localparam logic [7:0] IntLen    = 8'd4;

  typedef enum logic [3:0] {
    K_IDHI   = 4'd0,
    K_IDLO   = 4'd1,
    K_HEALTH = 4'd2,
    K_TIME   = 4'd3,
    K_COUNT  = 4'd4,
    K_KEY    = 4'd5,
    K_DOUBLE = 4'd6,
    K_INT    = 4'd7,
    K_STR    = 4'd8,
    K_PEND   = 4'd9,
    K_OK     = 4'd10,
    K_SHORT  = 4'd11,
    K_BAD    = 4'd12
  } kind_e;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_KEYLEN,
    PH_KEY,
    PH_TYPE,
    PH_VALUE,
    PH_STRLEN,
    PH_STRING,
    PH_SKIP
  } phase_e;

  typedef enum logic [2:0] {
    S_IDHI,
    S_IDLO,
    S_HEALTH,
    S_TIME,
    S_COUNT,
    S_ITEM,
    S_PEND,
    S_OK
  } step_e;

  // One command word from the front: an optional header group or single
  // item, then an optional parameter end, then an optional packet close.
  typedef struct packed {
    logic        hdr;
    logic        item;
    kind_e       kind;
    logic        item_last;
    logic [63:0] value;      // item value, or the timestamp for a header
    logic [15:0] index;
    logic        pend;
    logic        present;
    logic        ok;
    logic [63:0] id_hi;
    logic [63:0] id_lo;
    logic [7:0]  health;
    logic [15:0] count;
  } cmd_t;

endpackage

### rtl/core/tlvp_front.sv
// ----------------------------------------------------------------------------
// tlvp_front
// Byte parser: tracks header and parameter fields, issues command words.
// ----------------------------------------------------------------------------
module tlvp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    packet_byte_i,
  input  logic          end_of_packet_i,
  output logic          push_o,
  output tlvp_pkg::cmd_t cmd_o
);
  import tlvp_pkg::*;

  logic [4:0]  pos_q, pos_d;
  phase_e      phase_q, phase_d;
  logic [63:0] id0_q, id0_d, id1_q, id1_d;
  logic [7:0]  health_q, health_d;
  logic [63:0] ts_q, ts_d;
  logic [15:0] count_q, count_d;
  logic [15:0] done_q, done_d;
  logic [7:0]  left_q, left_d;
  logic [63:0] gather_q, gather_d;
  logic [7:0]  vtype_q, vtype_d;
  logic        bad_q, bad_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= PH_HEADER;
      id0_q    <= '0;
      id1_q    <= '0;
      health_q <= '0;
      ts_q     <= '0;
      count_q  <= '0;
      done_q   <= '0;
      left_q   <= '0;
      gather_q <= '0;
      vtype_q  <= '0;
      bad_q    <= 1'b0;
    end else if (accept_i) begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      id0_q    <= id0_d;
      id1_q    <= id1_d;
      health_q <= health_d;
      ts_q     <= ts_d;
      count_q  <= count_d;
      done_q   <= done_d;
      left_q   <= left_d;
      gather_q <= gather_d;
      vtype_q  <= vtype_d;
      bad_q    <= bad_d;
    end
  end

  logic [7:0]  b;
  logic        eop;
  logic        restart;
  logic [15:0] count_new;
  logic [15:0] done_inc;
  logic [7:0]  left_dec;
  logic [7:0]  total;
  logic [2:0]  lane;
  logic [63:0] gather_new;

  assign b         = packet_byte_i;
  assign eop       = end_of_packet_i;
  assign count_new = {count_q[7:0], b};
  assign done_inc  = done_q + 16'd1;
  assign left_dec  = left_q - 8'd1;
  assign total     = (vtype_q == TypeDouble) ? DoubleLen : IntLen;
  assign lane      = 3'(total - left_q);

  always_comb begin
    gather_new = gather_q;
    for (int i = 0; i < 8; i++) begin
      if (lane == 3'(i)) gather_new[8*i +: 8] = gather_q[8*i +: 8] | b;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    id0_d    = id0_q;
    id1_d    = id1_q;
    health_d = health_q;
    ts_d     = ts_q;
    count_d  = count_q;
    done_d   = done_q;
    left_d   = left_q;
    gather_d = gather_q;
    vtype_d  = vtype_q;
    bad_d    = bad_q;
    restart  = 1'b0;

    cmd_o           = '0;
    cmd_o.kind      = K_KEY;
    cmd_o.id_hi     = id0_q;
    cmd_o.id_lo     = id1_q;
    cmd_o.health    = health_q;
    cmd_o.count     = count_new;

    unique case (phase_q)
      PH_HEADER: begin
        if (pos_q < PosIdHiStart) begin
          if (b != Magic[pos_q[1:0]]) bad_d = 1'b1;
        end else if (pos_q < PosIdLoStart) begin
          id0_d = {id0_q[55:0], b};
        end else if (pos_q < PosHealth) begin
          id1_d = {id1_q[55:0], b};
        end else if (pos_q == PosHealth) begin
          health_d = b;
        end else if (pos_q < PosCountHi) begin
          ts_d = {ts_q[55:0], b};
        end else begin
          count_d = count_new;
        end
        if (pos_q != PosLast) begin
          if (eop) begin
            cmd_o.item      = 1'b1;
            cmd_o.kind      = K_SHORT;
            cmd_o.item_last = 1'b1;
            restart         = 1'b1;
          end else begin
            pos_d = pos_q + 5'd1;
          end
        end else if (bad_d) begin
          cmd_o.item      = 1'b1;
          cmd_o.kind      = K_BAD;
          cmd_o.item_last = 1'b1;
          if (eop) restart = 1'b1;
          else phase_d = PH_SKIP;
        end else begin
          cmd_o.hdr   = 1'b1;
          cmd_o.value = ts_q;
          if (count_new == 16'd0 || eop) begin
            cmd_o.ok = 1'b1;
            if (eop) restart = 1'b1;
            else phase_d = PH_SKIP;
          end else begin
            phase_d = PH_KEYLEN;
          end
        end
      end

      PH_KEYLEN: begin
        if (eop) begin
          cmd_o.ok = 1'b1;
          restart  = 1'b1;
        end else begin
          left_d  = b;
          phase_d = (b == 8'd0) ? PH_TYPE : PH_KEY;
        end
      end

      PH_KEY: begin
        cmd_o.item  = 1'b1;
        cmd_o.kind  = K_KEY;
        cmd_o.value = {56'd0, b};
        cmd_o.index = done_q;
        if (eop) begin
          cmd_o.ok = 1'b1;
          restart  = 1'b1;
        end else begin
          left_d = left_dec;
          if (left_dec == 8'd0) phase_d = PH_TYPE;
        end
      end

      PH_TYPE: begin
        vtype_d  = b;
        gather_d = '0;
        if ((b == TypeDouble || b == TypeInt || b == TypeString) && !eop) begin
          if (b == TypeString) begin
            phase_d = PH_STRLEN;
          end else begin
            left_d  = (b == TypeDouble) ? DoubleLen : IntLen;
            phase_d = PH_VALUE;
          end
        end else begin
          cmd_o.pend = 1'b1;
        end
      end

      PH_VALUE: begin
        left_d = left_dec;
        if (left_dec != 8'd0) begin
          gather_d = gather_new;
          if (eop) cmd_o.pend = 1'b1;
        end else begin
          cmd_o.item  = 1'b1;
          cmd_o.index = done_q;
          if (vtype_q == TypeDouble) begin
            cmd_o.kind  = K_DOUBLE;
            cmd_o.value = gather_new;
          end else begin
            cmd_o.kind  = K_INT;
            cmd_o.value = {{32{gather_new[31]}}, gather_new[31:0]};
          end
          cmd_o.pend    = 1'b1;
          cmd_o.present = 1'b1;
        end
      end

      PH_STRLEN: begin
        if (b == 8'd0) begin
          cmd_o.pend    = 1'b1;
          cmd_o.present = 1'b1;
        end else if (eop) begin
          cmd_o.pend = 1'b1;
        end else begin
          left_d  = b;
          phase_d = PH_STRING;
        end
      end

      PH_STRING: begin
        cmd_o.item  = 1'b1;
        cmd_o.kind  = K_STR;
        cmd_o.value = {56'd0, b};
        cmd_o.index = done_q;
        left_d      = left_dec;
        if (left_dec == 8'd0) begin
          cmd_o.pend    = 1'b1;
          cmd_o.present = 1'b1;
        end else if (eop) begin
          cmd_o.pend = 1'b1;
        end
      end

      PH_SKIP: begin
        if (eop) restart = 1'b1;
      end

      default: ;
    endcase

    // Parameter end: advance the count, or close the packet
    if (cmd_o.pend) begin
      cmd_o.index = done_q;
      if (!cmd_o.present && eop) begin
        cmd_o.ok = 1'b1;
        restart  = 1'b1;
      end else begin
        done_d = done_inc;
        if (done_inc == count_q || eop) begin
          cmd_o.ok = 1'b1;
          if (eop) restart = 1'b1;
          else phase_d = PH_SKIP;
        end else begin
          phase_d = PH_KEYLEN;
        end
      end
    end

    if (restart) begin
      pos_d    = '0;
      phase_d  = PH_HEADER;
      id0_d    = '0;
      id1_d    = '0;
      health_d = '0;
      ts_d     = '0;
      count_d  = '0;
      done_d   = '0;
      left_d   = '0;
      gather_d = '0;
      vtype_d  = '0;
      bad_d    = 1'b0;
    end
  end

  assign push_o = accept_i && (cmd_o.hdr || cmd_o.item || cmd_o.pend || cmd_o.ok);

endmodule

### rtl/core/tlvp_queue.sv
// ----------------------------------------------------------------------------
// tlvp_queue
// Small register queue of command words between front and back.
// ----------------------------------------------------------------------------
module tlvp_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tlvp_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tlvp_pkg::cmd_t head_o
);
  import tlvp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? ((wr_q == PtrLast) ? '0 : wr_q + PtrW'(1)) : wr_q;
    rd_d  = do_pop ? ((rd_q == PtrLast) ? '0 : rd_q + PtrW'(1)) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

endmodule

### rtl/core/tlvp_back.sv
// ----------------------------------------------------------------------------
// tlvp_back
// Expands command words into result words, one per cycle while the output
// is not stalled, into an output register.
// ----------------------------------------------------------------------------
module tlvp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  tlvp_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [3:0]     result_kind_o,
  output logic [63:0]    result_value_o,
  output logic [15:0]    parameter_index_o,
  output logic           value_present_o,
  output logic           last_of_packet_o
);
  import tlvp_pkg::*;

  cmd_t        cur_q, cur_d;
  logic        cur_valid_q, cur_valid_d;
  step_e       step_q, step_d;
  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [63:0] value_q, value_d;
  logic [15:0] index_q, index_d;
  logic        present_q, present_d;
  logic        last_q, last_d;

  logic  emit, done;
  step_e nxt, first;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= S_OK;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    kind_q    <= kind_d;
    value_q   <= value_d;
    index_q   <= index_d;
    present_q <= present_d;
    last_q    <= last_d;
  end

  always_comb begin
    first = head_i.hdr ? S_IDHI : head_i.item ? S_ITEM : head_i.pend ? S_PEND : S_OK;

    done = 1'b0;
    nxt  = S_OK;
    unique case (step_q)
      S_IDHI:   nxt = S_IDLO;
      S_IDLO:   nxt = S_HEALTH;
      S_HEALTH: nxt = S_TIME;
      S_TIME:   nxt = S_COUNT;
      S_COUNT:  done = !cur_q.ok;
      S_ITEM: begin
        if (cur_q.pend) nxt = S_PEND;
        else done = !cur_q.ok;
      end
      S_PEND:   done = !cur_q.ok;
      S_OK:     done = 1'b1;
      default:  done = 1'b1;
    endcase

    emit  = cur_valid_q && (!out_valid_q || !out_stall_i);
    pop_o = (!cur_valid_q || (emit && done)) && !empty_i;

    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    step_d      = step_q;
    if (!cur_valid_q || (emit && done)) begin
      cur_valid_d = !empty_i;
      // load only a real head word
      if (!empty_i) begin
        cur_d  = head_i;
        step_d = first;
      end
    end else if (emit) begin
      step_d = nxt;
    end

    out_valid_d = emit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
    kind_d      = kind_q;
    value_d     = value_q;
    index_d     = index_q;
    present_d   = present_q;
    last_d      = last_q;
    if (emit) begin
      value_d   = '0;
      index_d   = '0;
      present_d = 1'b0;
      last_d    = 1'b0;
      unique case (step_q)
        S_IDHI: begin
          kind_d  = K_IDHI;
          value_d = cur_q.id_hi;
        end
        S_IDLO: begin
          kind_d  = K_IDLO;
          value_d = cur_q.id_lo;
        end
        S_HEALTH: begin
          kind_d  = K_HEALTH;
          value_d = {56'd0, cur_q.health};
        end
        S_TIME: begin
          kind_d  = K_TIME;
          value_d = cur_q.value;
        end
        S_COUNT: begin
          kind_d  = K_COUNT;
          value_d = {48'd0, cur_q.count};
        end
        S_ITEM: begin
          kind_d  = cur_q.kind;
          value_d = cur_q.value;
          index_d = cur_q.index;
          last_d  = cur_q.item_last;
        end
        S_PEND: begin
          kind_d    = K_PEND;
          index_d   = cur_q.index;
          present_d = cur_q.present;
        end
        S_OK: begin
          kind_d = K_OK;
          last_d = 1'b1;
        end
        default: kind_d = K_OK;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = kind_q;
  assign result_value_o    = value_q;
  assign parameter_index_o = index_q;
  assign value_present_o   = present_q;
  assign last_of_packet_o  = last_q;

endmodule

### rtl/core/telemetry_frame_tlv_parser_top.sv
// ----------------------------------------------------------------------------
// telemetry_frame_tlv_parser_top
// Streaming telemetry frame parser: header check and TLV parameter results.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------
//   in       | input     | in_valid_i / in_stall_o | packet_byte_i, end_of_packet_i
//   out      | output    | out_valid_o/out_stall_i | result_kind_o, result_value_o,
//            |           |                        | parameter_index_o,
//            |           |                        | value_present_o, last_of_packet_o
//
// The front takes one byte per cycle while the command queue has room.
// The back sends one result word per cycle while out_stall_i is low; a byte
// makes up to six results (the last header byte), so the output port sets the
// sustained rate.
// Reset clears all parser state and empties the queue; no clearing pass.
// in_stall_o is high exactly while the command queue is full.
// ----------------------------------------------------------------------------
module telemetry_frame_tlv_parser_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  packet_byte_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  result_kind_o,
  output logic [63:0] result_value_o,
  output logic [15:0] parameter_index_o,
  output logic        value_present_o,
  output logic        last_of_packet_o
);
  import tlvp_pkg::*;

  logic accept;
  logic push, full, pop, empty;
  cmd_t cmd, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  tlvp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .packet_byte_i  (packet_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .push_o         (push),
    .cmd_o          (cmd)
  );

  tlvp_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .head_o (head)
  );

  tlvp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .result_value_o   (result_value_o),
    .parameter_index_o(parameter_index_o),
    .value_present_o  (value_present_o),
    .last_of_packet_o (last_of_packet_o)
  );

  // A command is never offered to a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("command pushed into full queue");

  // Header words leave back to back once the upper id word is taken
  a_hdr_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && result_kind_o == K_IDHI)
      |=> (out_valid_o && result_kind_o == K_IDLO))
    else $error("header words not contiguous");

  // Packet close marks only on closing kinds, present flag only on parameter end
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((!last_of_packet_o || result_kind_o == K_OK || result_kind_o == K_SHORT ||
        result_kind_o == K_BAD) &&
       (!value_present_o || result_kind_o == K_PEND)))
    else $error("result flags inconsistent with kind");

endmodule
